>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed: expr");
// same-cycle implication
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: ante -> cons");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: ante => cons");
`else
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> rtl/fsge_pkg.sv
// ----------------------------------------------------------------------------
// fsge_pkg
// Types, constants and helpers for the falling sand grid engine.
// ----------------------------------------------------------------------------
package fsge_pkg;

    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    localparam int CELL_W    = 25;  // bit 24 grain, 23..0 color
    localparam int COLOR_W   = 24;
    localparam int MOVED_W   = 13;
    localparam int DIM_W     = 7;
    localparam int PROB_W    = 9;
    localparam int SEED_W    = 32;
    localparam int POS_W     = 6;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 32'h8020_0003;

    localparam logic [DIM_W-1:0]   RST_ACTIVE_DIM = 7'd64;
    localparam logic [DIM_W-1:0]   RST_BRUSH      = 7'd8;
    localparam logic [PROB_W-1:0]  RST_PROB       = 9'd256;
    localparam logic [COLOR_W-1:0] RST_COLOR      = 24'hFF_FFFF;
    localparam logic [SEED_W-1:0]  RST_SEED       = 32'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PAINT = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_WIDTH  = 3'd0,
        CFG_ACTIVE_HEIGHT = 3'd1,
        CFG_BRUSH_SIZE    = 3'd2,
        CFG_PAINT_PROB    = 3'd3,
        CFG_PAINT_COLOR   = 3'd4,
        CFG_RNG_SEED      = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DIR_DOWN  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_PAINT,
        ST_RD_ISSUE,
        ST_RD_WAIT,
        ST_STEP_CLR,
        ST_SRC,
        ST_SRC_W,
        ST_DN,
        ST_DN_W,
        ST_DL,
        ST_DL_W,
        ST_DR,
        ST_DR_W,
        ST_MOVE,
        ST_DONE
    } state_t;

    // Galois LFSR, shift right
    function automatic logic [SEED_W-1:0] lfsr_adv(input logic [SEED_W-1:0] r);
        logic [SEED_W-1:0] s;
        s = r >> 1;
        if (r[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

>>> rtl/fsge_ram.sv
// ----------------------------------------------------------------------------
// fsge_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fsge_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/falling_sand_grid_engine_core.sv
// ----------------------------------------------------------------------------
// falling_sand_grid_engine_core
// Falling sand cellular automaton over a ping-pong pair of grid RAMs.
// ----------------------------------------------------------------------------
// Commands: read (skips the grid read outside the area), clear, paint (s*s brush)
// and step (next grid swept, then the active area scanned, grains probing below).
// DEPTH = padded grid size. One item at a time; step time is set by the
// single read port per grid RAM, with each neighbor probe taking an issue and
// a capture state. Reset is synchronous, active low; after reset the current
// grid is swept empty over all DEPTH addresses (4096 at 64x64) before s_tready
// rises. A write to active_width or active_height while idle starts the same sweep.
module falling_sand_grid_engine_core #(
    parameter int GRID_WIDTH  = fsge_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = fsge_pkg::GRID_HEIGHT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fsge_pkg::S_TDATA_W-1:0] s_tdata,  // pos_x[5:0], pos_y[11:6], zero pad
    input  logic [fsge_pkg::CMD_W-1:0]     s_tuser,  // cmd[1:0]
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fsge_pkg::M_TDATA_W-1:0] m_tdata,  // cell_is_sand[0], cell_color[24:1],
                                                     // grains_moved[37:25], zero pad
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [fsge_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [fsge_pkg::SEED_W-1:0]    cfg_wdata
);

    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 1 << AW;
    // signed work width: coordinates, dimensions and brush math
    localparam int MW    = (XW > YW) ? XW : YW;
    localparam int CW    = ((MW > fsge_pkg::POS_W) ? MW : fsge_pkg::POS_W) + 2;
    localparam int CELL_W = fsge_pkg::CELL_W;
    localparam logic [fsge_pkg::MOVED_W-1:0] MOVED_W_ONE = 1;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    fsge_pkg::state_t state_reg, state_next;

    logic [fsge_pkg::DIM_W-1:0]   act_w_reg, act_w_next;
    logic [fsge_pkg::DIM_W-1:0]   act_h_reg, act_h_next;
    logic [fsge_pkg::DIM_W-1:0]   brush_reg, brush_next;
    logic [fsge_pkg::PROB_W-1:0]  prob_reg, prob_next;
    logic [fsge_pkg::COLOR_W-1:0] color_reg, color_next;
    logic [fsge_pkg::SEED_W-1:0]  rng_reg, rng_next;

    logic                         cur_sel_reg, cur_sel_next;   // bank holding current grid
    logic [AW-1:0]                clr_addr_reg, clr_addr_next;
    logic                         clr_rsp_reg, clr_rsp_next;   // sweep owes a result
    logic [XW-1:0]                x_reg, x_next;
    logic [YW-1:0]                y_reg, y_next;
    logic [YW-1:0]                y0_reg, y0_next;
    logic [XW-1:0]                x_last_reg, x_last_next;
    logic [YW-1:0]                y_last_reg, y_last_next;
    logic [CELL_W-1:0]            grain_reg, grain_next;
    logic                         inb_reg, inb_next;
    logic                         lfree_reg, lfree_next;
    fsge_pkg::dir_t               dir_reg, dir_next;
    logic [fsge_pkg::MOVED_W-1:0] moved_reg, moved_next;

    logic                         rsp_sand_reg, rsp_sand_next;
    logic [fsge_pkg::COLOR_W-1:0] rsp_color_reg, rsp_color_next;
    logic [fsge_pkg::MOVED_W-1:0] rsp_moved_reg, rsp_moved_next;

    logic                         m_tvalid_reg, m_tvalid_next;
    logic [fsge_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // ------------------------------------------------------------------
    // Grid RAM ports: logical current/next mapped onto the two banks
    // ------------------------------------------------------------------
    logic              cur_we, nxt_we;
    logic [AW-1:0]     cur_waddr, nxt_waddr, cur_raddr, nxt_raddr;
    logic [CELL_W-1:0] cur_wdata, nxt_wdata, cur_rdata, nxt_rdata;

    logic              b0_we, b1_we;
    logic [AW-1:0]     b0_waddr, b1_waddr, b0_raddr, b1_raddr;
    logic [CELL_W-1:0] b0_wdata, b1_wdata, b0_rdata, b1_rdata;

    assign b0_we     = cur_sel_reg ? nxt_we    : cur_we;
    assign b0_waddr  = cur_sel_reg ? nxt_waddr : cur_waddr;
    assign b0_wdata  = cur_sel_reg ? nxt_wdata : cur_wdata;
    assign b0_raddr  = cur_sel_reg ? nxt_raddr : cur_raddr;
    assign b1_we     = cur_sel_reg ? cur_we    : nxt_we;
    assign b1_waddr  = cur_sel_reg ? cur_waddr : nxt_waddr;
    assign b1_wdata  = cur_sel_reg ? cur_wdata : nxt_wdata;
    assign b1_raddr  = cur_sel_reg ? cur_raddr : nxt_raddr;
    assign cur_rdata = cur_sel_reg ? b1_rdata  : b0_rdata;
    assign nxt_rdata = cur_sel_reg ? b0_rdata  : b1_rdata;

    fsge_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_bank0 (
        .aclk  (aclk),
        .we    (b0_we),
        .waddr (b0_waddr),
        .wdata (b0_wdata),
        .raddr (b0_raddr),
        .rdata (b0_rdata)
    );

    fsge_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_bank1 (
        .aclk  (aclk),
        .we    (b1_we),
        .waddr (b1_waddr),
        .wdata (b1_wdata),
        .raddr (b1_raddr),
        .rdata (b1_rdata)
    );

    // ------------------------------------------------------------------
    // Effective dimensions: 0 acts as 1, above the grid acts as the grid
    // ------------------------------------------------------------------
    logic [CW-1:0] w_eff, h_eff;

    always_comb begin
        if (act_w_reg == '0) begin
            w_eff = CW'(1);
        end else if (CW'(act_w_reg) > CW'(GRID_WIDTH)) begin
            w_eff = CW'(GRID_WIDTH);
        end else begin
            w_eff = CW'(act_w_reg);
        end
        if (act_h_reg == '0) begin
            h_eff = CW'(1);
        end else if (CW'(act_h_reg) > CW'(GRID_HEIGHT)) begin
            h_eff = CW'(GRID_HEIGHT);
        end else begin
            h_eff = CW'(act_h_reg);
        end
    end

    // ------------------------------------------------------------------
    // Input decode and brush setup
    // ------------------------------------------------------------------
    fsge_pkg::cmd_t              in_cmd;
    logic [fsge_pkg::POS_W-1:0]  in_px, in_py;
    logic [CW-1:0]               px_e, py_e, brush_lim, brush_s, brush_half;
    logic signed [CW-1:0]        bx0, by0, bx_max, by_max;
    logic                        rd_in_range;
    logic                        s_fire;

    assign in_cmd = fsge_pkg::cmd_t'(s_tuser);
    assign in_px  = s_tdata[fsge_pkg::POS_W-1:0];
    assign in_py  = s_tdata[2*fsge_pkg::POS_W-1:fsge_pkg::POS_W];
    assign px_e   = CW'(in_px);
    assign py_e   = CW'(in_py);
    assign s_fire = s_tvalid && s_tready;
    assign rd_in_range = (px_e < w_eff) && (py_e < h_eff);

    always_comb begin
        brush_lim = (w_eff < h_eff) ? w_eff : h_eff;
        if (brush_reg == '0) begin
            brush_s = CW'(1);
        end else if (CW'(brush_reg) > brush_lim) begin
            brush_s = brush_lim;
        end else begin
            brush_s = CW'(brush_reg);
        end
        brush_half = brush_s >> 1;
        bx_max = $signed(w_eff - brush_s);
        by_max = $signed(h_eff - brush_s);
        bx0 = $signed(px_e - brush_half);
        by0 = $signed(py_e - brush_half);
        if (bx0 > bx_max) begin
            bx0 = bx_max;
        end
        if (bx0 < $signed(CW'(0))) begin
            bx0 = '0;
        end
        if (by0 > by_max) begin
            by0 = by_max;
        end
        if (by0 < $signed(CW'(0))) begin
            by0 = '0;
        end
    end

    // ------------------------------------------------------------------
    // Shared neighbor probe: address and bounds of the cell below
    // the scan position, offset by the selected direction
    // ------------------------------------------------------------------
    fsge_pkg::dir_t probe_dir;
    logic [CW-1:0]  nx_e, ny_e;
    logic           probe_inb;
    logic [AW-1:0]  probe_addr;
    logic [AW-1:0]  src_addr;
    logic           free_now;

    always_comb begin
        case (state_reg)
            fsge_pkg::ST_DL, fsge_pkg::ST_DL_W: probe_dir = fsge_pkg::DIR_LEFT;
            fsge_pkg::ST_DR, fsge_pkg::ST_DR_W: probe_dir = fsge_pkg::DIR_RIGHT;
            fsge_pkg::ST_MOVE:                  probe_dir = dir_reg;
            default:                            probe_dir = fsge_pkg::DIR_DOWN;
        endcase
    end

    always_comb begin
        ny_e = CW'(y_reg) + CW'(1);
        case (probe_dir)
            fsge_pkg::DIR_LEFT:  nx_e = CW'(x_reg) - CW'(1);
            fsge_pkg::DIR_RIGHT: nx_e = CW'(x_reg) + CW'(1);
            default:             nx_e = CW'(x_reg);
        endcase
        if (probe_dir == fsge_pkg::DIR_LEFT) begin
            probe_inb = (ny_e < h_eff) && (x_reg != '0);
        end else begin
            probe_inb = (ny_e < h_eff) && (nx_e < w_eff);
        end
        probe_addr = {ny_e[YW-1:0], nx_e[XW-1:0]};
    end

    assign src_addr = {y_reg, x_reg};
    // target free: inside the area, empty in both grids
    assign free_now = inb_reg && !cur_rdata[CELL_W-1] && !nxt_rdata[CELL_W-1];

    // scan and paint progress
    logic scan_x_end, scan_last, paint_y_end, paint_last, clr_end, cfg_resize;

    assign scan_x_end  = (CW'(x_reg) == w_eff - CW'(1));
    assign scan_last   = scan_x_end && (y_reg == '0);
    assign paint_y_end = (y_reg == y_last_reg);
    assign paint_last  = paint_y_end && (x_reg == x_last_reg);
    assign clr_end     = (clr_addr_reg == {AW{1'b1}});
    assign cfg_resize  = cfg_wr_en && ((cfg_addr == fsge_pkg::CFG_ACTIVE_WIDTH) ||
                                       (cfg_addr == fsge_pkg::CFG_ACTIVE_HEIGHT));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fsge_pkg::ST_CLR: begin
                if (clr_end) begin
                    state_next = clr_rsp_reg ? fsge_pkg::ST_DONE : fsge_pkg::ST_IDLE;
                end
            end
            fsge_pkg::ST_IDLE: begin
                if (cfg_resize) begin
                    state_next = fsge_pkg::ST_CLR;
                end else if (s_fire) begin
                    unique case (in_cmd)
                        fsge_pkg::CMD_PAINT: state_next = fsge_pkg::ST_PAINT;
                        fsge_pkg::CMD_STEP:  state_next = fsge_pkg::ST_STEP_CLR;
                        fsge_pkg::CMD_READ:  state_next = rd_in_range ? fsge_pkg::ST_RD_ISSUE
                                                                      : fsge_pkg::ST_DONE;
                        default:             state_next = fsge_pkg::ST_CLR;
                    endcase
                end
            end
            fsge_pkg::ST_PAINT:    if (paint_last) state_next = fsge_pkg::ST_DONE;
            fsge_pkg::ST_RD_ISSUE: state_next = fsge_pkg::ST_RD_WAIT;
            fsge_pkg::ST_RD_WAIT:  state_next = fsge_pkg::ST_DONE;
            fsge_pkg::ST_STEP_CLR: if (clr_end) state_next = fsge_pkg::ST_SRC;
            fsge_pkg::ST_SRC:      state_next = fsge_pkg::ST_SRC_W;
            fsge_pkg::ST_SRC_W: begin
                if (cur_rdata[CELL_W-1]) begin
                    state_next = fsge_pkg::ST_DN;
                end else begin
                    state_next = scan_last ? fsge_pkg::ST_DONE : fsge_pkg::ST_SRC;
                end
            end
            fsge_pkg::ST_DN:   state_next = fsge_pkg::ST_DN_W;
            fsge_pkg::ST_DN_W: state_next = free_now ? fsge_pkg::ST_MOVE : fsge_pkg::ST_DL;
            fsge_pkg::ST_DL:   state_next = fsge_pkg::ST_DL_W;
            fsge_pkg::ST_DL_W: state_next = fsge_pkg::ST_DR;
            fsge_pkg::ST_DR:   state_next = fsge_pkg::ST_DR_W;
            fsge_pkg::ST_DR_W: begin
                if (lfree_reg || free_now) begin
                    state_next = fsge_pkg::ST_MOVE;
                end else begin
                    state_next = scan_last ? fsge_pkg::ST_DONE : fsge_pkg::ST_SRC;
                end
            end
            fsge_pkg::ST_MOVE: state_next = scan_last ? fsge_pkg::ST_DONE : fsge_pkg::ST_SRC;
            fsge_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = fsge_pkg::ST_IDLE;
                end
            end
            default: state_next = fsge_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and outputs
    // ------------------------------------------------------------------
    always_comb begin
        act_w_next     = act_w_reg;
        act_h_next     = act_h_reg;
        brush_next     = brush_reg;
        prob_next      = prob_reg;
        color_next     = color_reg;
        rng_next       = rng_reg;
        cur_sel_next   = cur_sel_reg;
        clr_addr_next  = clr_addr_reg;
        clr_rsp_next   = clr_rsp_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        y0_next        = y0_reg;
        x_last_next    = x_last_reg;
        y_last_next    = y_last_reg;
        grain_next     = grain_reg;
        inb_next       = inb_reg;
        lfree_next     = lfree_reg;
        dir_next       = dir_reg;
        moved_next     = moved_reg;
        rsp_sand_next  = rsp_sand_reg;
        rsp_color_next = rsp_color_reg;
        rsp_moved_next = rsp_moved_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        cur_we    = 1'b0;
        cur_waddr = src_addr;
        cur_wdata = '0;
        cur_raddr = src_addr;
        nxt_we    = 1'b0;
        nxt_waddr = probe_addr;
        nxt_wdata = grain_reg;
        nxt_raddr = probe_addr;

        unique case (state_reg)
            fsge_pkg::ST_CLR: begin
                cur_we        = 1'b1;
                cur_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            fsge_pkg::ST_IDLE: begin
                if (s_fire) begin
                    rsp_sand_next  = 1'b0;
                    rsp_color_next = '0;
                    rsp_moved_next = '0;
                    clr_addr_next  = '0;
                    clr_rsp_next   = 1'b1;
                    moved_next     = '0;
                    unique case (in_cmd)
                        fsge_pkg::CMD_PAINT: begin
                            x_next      = bx0[XW-1:0];
                            y_next      = by0[YW-1:0];
                            y0_next     = by0[YW-1:0];
                            x_last_next = XW'(bx0 + $signed(brush_s) - $signed(CW'(1)));
                            y_last_next = YW'(by0 + $signed(brush_s) - $signed(CW'(1)));
                        end
                        fsge_pkg::CMD_STEP: begin
                            x_next = '0;
                            y_next = YW'(h_eff - CW'(1));
                        end
                        fsge_pkg::CMD_READ: begin
                            x_next = XW'(in_px);
                            y_next = YW'(in_py);
                        end
                        default: ;
                    endcase
                end
            end
            fsge_pkg::ST_PAINT: begin
                rng_next  = fsge_pkg::lfsr_adv(rng_reg);
                cur_we    = ({1'b0, rng_next[7:0]} < prob_reg);
                cur_wdata = {1'b1, color_reg};
                if (paint_y_end) begin
                    y_next = y0_reg;
                    x_next = x_reg + XW'(1);
                end else begin
                    y_next = y_reg + YW'(1);
                end
            end
            fsge_pkg::ST_RD_ISSUE: ;
            fsge_pkg::ST_RD_WAIT: begin
                rsp_sand_next  = cur_rdata[CELL_W-1];
                rsp_color_next = cur_rdata[CELL_W-1] ? cur_rdata[fsge_pkg::COLOR_W-1:0] : '0;
            end
            fsge_pkg::ST_STEP_CLR: begin
                nxt_we        = 1'b1;
                nxt_waddr     = clr_addr_reg;
                nxt_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
            end
            fsge_pkg::ST_SRC: ;
            fsge_pkg::ST_SRC_W: begin
                grain_next = cur_rdata;
            end
            fsge_pkg::ST_DN, fsge_pkg::ST_DL, fsge_pkg::ST_DR: begin
                // probe both grids at the target cell
                cur_raddr = probe_addr;
                inb_next  = probe_inb;
            end
            fsge_pkg::ST_DN_W: begin
                dir_next = fsge_pkg::DIR_DOWN;
            end
            fsge_pkg::ST_DL_W: begin
                lfree_next = free_now;
            end
            fsge_pkg::ST_DR_W: begin
                if (lfree_reg && free_now) begin
                    rng_next = fsge_pkg::lfsr_adv(rng_reg);
                    dir_next = rng_next[0] ? fsge_pkg::DIR_RIGHT : fsge_pkg::DIR_LEFT;
                end else if (lfree_reg) begin
                    dir_next = fsge_pkg::DIR_LEFT;
                end else if (free_now) begin
                    dir_next = fsge_pkg::DIR_RIGHT;
                end else begin
                    // blocked: grain stays in place
                    nxt_we    = 1'b1;
                    nxt_waddr = src_addr;
                end
            end
            fsge_pkg::ST_MOVE: begin
                nxt_we     = 1'b1;
                cur_we     = 1'b1;       // source emptied at once
                moved_next = moved_reg + MOVED_W_ONE;
            end
            fsge_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = fsge_pkg::M_TDATA_W'({rsp_moved_reg, rsp_color_reg,
                                                          rsp_sand_reg});
                end
            end
            default: ;
        endcase

        // scan advance after a cell is finished
        if ((state_reg == fsge_pkg::ST_SRC_W && !cur_rdata[CELL_W-1]) ||
            (state_reg == fsge_pkg::ST_DR_W && !lfree_reg && !free_now) ||
            (state_reg == fsge_pkg::ST_MOVE)) begin
            if (scan_last) begin
                cur_sel_next   = ~cur_sel_reg;
                rsp_moved_next = moved_next;
            end else if (scan_x_end) begin
                x_next = '0;
                y_next = y_reg - YW'(1);
            end else begin
                x_next = x_reg + XW'(1);
            end
        end

        // configuration writes
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                fsge_pkg::CFG_ACTIVE_WIDTH: begin
                    act_w_next    = cfg_wdata[fsge_pkg::DIM_W-1:0];
                    clr_addr_next = '0;
                    clr_rsp_next  = 1'b0;
                end
                fsge_pkg::CFG_ACTIVE_HEIGHT: begin
                    act_h_next    = cfg_wdata[fsge_pkg::DIM_W-1:0];
                    clr_addr_next = '0;
                    clr_rsp_next  = 1'b0;
                end
                fsge_pkg::CFG_BRUSH_SIZE:  brush_next = cfg_wdata[fsge_pkg::DIM_W-1:0];
                fsge_pkg::CFG_PAINT_PROB:  prob_next  = cfg_wdata[fsge_pkg::PROB_W-1:0];
                fsge_pkg::CFG_PAINT_COLOR: color_next = cfg_wdata[fsge_pkg::COLOR_W-1:0];
                fsge_pkg::CFG_RNG_SEED: begin
                    // zero would lock the LFSR
                    rng_next = (cfg_wdata == '0) ? fsge_pkg::RST_SEED : cfg_wdata;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Register update
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fsge_pkg::ST_CLR;
            act_w_reg    <= fsge_pkg::RST_ACTIVE_DIM;
            act_h_reg    <= fsge_pkg::RST_ACTIVE_DIM;
            brush_reg    <= fsge_pkg::RST_BRUSH;
            prob_reg     <= fsge_pkg::RST_PROB;
            color_reg    <= fsge_pkg::RST_COLOR;
            rng_reg      <= fsge_pkg::RST_SEED;
            cur_sel_reg  <= 1'b0;
            clr_addr_reg <= '0;
            clr_rsp_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            act_w_reg    <= act_w_next;
            act_h_reg    <= act_h_next;
            brush_reg    <= brush_next;
            prob_reg     <= prob_next;
            color_reg    <= color_next;
            rng_reg      <= rng_next;
            cur_sel_reg  <= cur_sel_next;
            clr_addr_reg <= clr_addr_next;
            clr_rsp_reg  <= clr_rsp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        y0_reg        <= y0_next;
        x_last_reg    <= x_last_next;
        y_last_reg    <= y_last_next;
        grain_reg     <= grain_next;
        inb_reg       <= inb_next;
        lfree_reg     <= lfree_next;
        dir_reg       <= dir_next;
        moved_reg     <= moved_next;
        rsp_sand_reg  <= rsp_sand_next;
        rsp_color_reg <= rsp_color_next;
        rsp_moved_reg <= rsp_moved_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign s_tready = (state_reg == fsge_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    logic step_scan, in_move, bank_swap, to_done;
    assign step_scan = (state_reg == fsge_pkg::ST_SRC) || (state_reg == fsge_pkg::ST_SRC_W) ||
                       (state_reg == fsge_pkg::ST_DN_W) || (state_reg == fsge_pkg::ST_DR_W) ||
                       (state_reg == fsge_pkg::ST_MOVE);
    assign in_move   = (state_reg == fsge_pkg::ST_MOVE);
    assign bank_swap = step_scan && (cur_sel_next != cur_sel_reg);
    assign to_done   = (state_next == fsge_pkg::ST_DONE);

    `ASSERT_ALWAYS(a_rng_nonzero, aclk, aresetn, rng_reg != '0)
    `ASSERT_IMPL(a_move_has_grain, aclk, aresetn, in_move, grain_reg[CELL_W-1])
    `ASSERT_IMPL(a_bank_swap_at_end, aclk, aresetn, bank_swap, to_done)
    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_fire && !cfg_wr_en, !s_tready)

endmodule
